>>> rtl/act_pkg.sv
package act_pkg;

    localparam int unsigned TableEntriesDefault = 16;
    localparam logic [31:0] RefreshAgeReset     = 32'd6000;

    localparam logic [1:0] KindTick    = 2'd0;
    localparam logic [1:0] KindResolve = 2'd1;
    localparam logic [1:0] KindPacket  = 2'd2;

    localparam logic [2:0] StatTick    = 3'd0;
    localparam logic [2:0] StatHit     = 3'd1;
    localparam logic [2:0] StatMiss    = 3'd2;
    localparam logic [2:0] StatLearned = 3'd3;
    localparam logic [2:0] StatDropped = 3'd4;

    localparam logic [15:0] OpRequest = 16'd1;
    localparam logic [15:0] OpReply   = 16'd2;
    localparam logic [15:0] HwEther   = 16'd1;
    localparam logic [15:0] ProtoIpv4 = 16'h0800;
    localparam logic [7:0]  HwLenMac  = 8'd6;
    localparam logic [7:0]  ProtoLenIp = 8'd4;

    localparam logic RegLocalIp    = 1'b0;
    localparam logic RegRefreshAge = 1'b1;

    // operation handed from front to back
    typedef enum logic [2:0] {
        OP_TICK,
        OP_RESOLVE,
        OP_LEARN_REQ,
        OP_LEARN_REP,
        OP_DROP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        no_send;
        logic [31:0] addr;
        logic [47:0] hw;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] cached_hw;
        logic        send_request;
        logic        send_reply;
        logic [31:0] reply_addr;
        logic [47:0] reply_hw;
    } t_res;

endpackage

>>> rtl/arp_cache_table_unit.sv
// channel  | handshake        | payload
// input    | i_push / o_full  | i_kind .. i_no_send
// result   | o_empty / i_pop  | o_status .. o_reply_hw
// config   | i_cfg_we         | i_cfg_index, i_cfg_data
// Ticks and dropped packets go from S_IDLE straight to S_EXEC; resolves and packets
// that touch the table first pass S_SCAN, the one-entry-a-cycle table scan, and S_READ.
// Reset clears valid bits, the clock and the queues at once; no clearing pass.
// A two-deep command queue lets input continue while the back part scans or
// waits on a full result register.
module arp_cache_table_unit
    import act_pkg::*;
#(
    parameter int unsigned TableEntries = TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_peer_addr,
    input  logic [47:0] i_sender_hw,
    input  logic [31:0] i_target_addr,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [7:0]  i_hw_len,
    input  logic [7:0]  i_proto_len,
    input  logic        i_no_send,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status,
    output logic [47:0] o_cached_hw,
    output logic        o_send_request,
    output logic        o_send_reply,
    output logic [31:0] o_reply_addr,
    output logic [47:0] o_reply_hw,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_local_ip, r_refresh_age;
    logic        cmd_valid, cmd_take, res_valid;
    t_cmd        cmd;
    t_res        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= 32'd0;
            r_refresh_age <= RefreshAgeReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegLocalIp:    r_local_ip    <= i_cfg_data;
                RegRefreshAge: r_refresh_age <= i_cfg_data;
                default: ;
            endcase
        end
    end

    act_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_kind, .i_peer_addr, .i_sender_hw,
        .i_target_addr, .i_opcode, .i_hw_type, .i_proto_type, .i_hw_len,
        .i_proto_len, .i_no_send,
        .i_local_ip  (r_local_ip),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    act_back #(.TableEntries(TableEntries)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .i_refresh_age (r_refresh_age),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_take    (i_pop)
    );

    assign o_empty        = !res_valid;
    assign o_status       = res.status;
    assign o_cached_hw    = res.cached_hw;
    assign o_send_request = res.send_request;
    assign o_send_reply   = res.send_reply;
    assign o_reply_addr   = res.reply_addr;
    assign o_reply_hw     = res.reply_hw;

endmodule

>>> rtl/act_front.sv
module act_front
    import act_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_peer_addr,
    input  logic [47:0] i_sender_hw,
    input  logic [31:0] i_target_addr,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [7:0]  i_hw_len,
    input  logic [7:0]  i_proto_len,
    input  logic        i_no_send,
    input  logic [31:0] i_local_ip,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    // two-entry command queue
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       hdr_ok;
    logic       do_push, do_pop;

    always_comb begin
        hdr_ok = (i_hw_type == HwEther) && (i_proto_type == ProtoIpv4)
              && (i_hw_len == HwLenMac) && (i_proto_len == ProtoLenIp);
        n_cmd.no_send = i_no_send;
        n_cmd.addr    = i_peer_addr;
        n_cmd.hw      = i_sender_hw;
        n_cmd.op      = OP_DROP;
        case (i_kind)
            KindTick:    n_cmd.op = OP_TICK;
            KindResolve: n_cmd.op = OP_RESOLVE;
            KindPacket: begin
                if (hdr_ok && i_opcode == OpRequest && i_local_ip != 32'd0
                    && i_target_addr == i_local_ip)
                    n_cmd.op = OP_LEARN_REQ;
                else if (hdr_ok && i_opcode == OpReply)
                    n_cmd.op = OP_LEARN_REP;
            end
            default: n_cmd.op = OP_DROP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign do_push     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign do_pop      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
        if (do_push) r_q[r_wp] <= n_cmd;
    end

endmodule

>>> rtl/act_back.sv
module act_back
    import act_pkg::*;
#(
    parameter int unsigned TableEntries = TableEntriesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    input  logic [31:0] i_refresh_age,
    output logic        o_res_valid,
    output t_res        o_res,
    input  logic        i_res_take
);

    localparam int unsigned IdxW = $clog2(TableEntries);
    localparam logic [IdxW:0] LastIdx = (IdxW+1)'(TableEntries - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_EXEC, S_OUT
    } t_state;

    logic [31:0] r_addr_mem [TableEntries];
    logic [47:0] r_hw_mem   [TableEntries];
    logic [31:0] r_use_mem  [TableEntries];
    logic [TableEntries-1:0] r_valid, r_resolved;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [31:0] r_now;
    logic [IdxW:0] r_i;
    logic        r_hit;
    logic [IdxW-1:0] r_hit_idx;
    logic        r_free;
    logic [IdxW-1:0] r_free_idx;
    logic        r_rv;
    logic [IdxW-1:0] r_rv_idx;
    logic [31:0] r_rv_age;
    logic        r_pv;
    logic [IdxW-1:0] r_pv_idx;
    logic [31:0] r_pv_age;
    logic [31:0] r_rd_use;
    logic [47:0] r_rd_hw;
    logic        r_res_valid;
    t_res        r_res;
    t_res        n_res;

    logic [IdxW-1:0] idx, slot;
    logic [31:0] age, hit_age;

    assign idx        = r_i[IdxW-1:0];
    assign age        = r_now - r_use_mem[idx];
    assign hit_age    = r_now - r_use_mem[r_hit_idx];
    assign slot       = r_hit ? r_hit_idx : r_free ? r_free_idx
                      : r_rv ? r_rv_idx : r_pv_idx;
    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_res = '0;
        n_res.status = StatDropped;
        case (r_cmd.op)
            OP_TICK: n_res.status = StatTick;
            OP_RESOLVE: begin
                if (r_hit && r_resolved[r_hit_idx]) begin
                    n_res.status    = StatHit;
                    n_res.cached_hw = r_rd_hw;
                    if (!r_cmd.no_send && r_rd_use > i_refresh_age) begin
                        n_res.send_request = 1'b1;
                        n_res.reply_addr   = r_cmd.addr;
                    end
                end else begin
                    n_res.status       = StatMiss;
                    n_res.send_request = 1'b1;
                    n_res.reply_addr   = r_cmd.addr;
                end
            end
            OP_LEARN_REQ: begin
                n_res.status     = StatLearned;
                n_res.send_reply = 1'b1;
                n_res.reply_addr = r_cmd.addr;
                n_res.reply_hw   = r_cmd.hw;
            end
            OP_LEARN_REP: begin
                if (r_hit) n_res.status = StatLearned;
            end
            default: n_res.status = StatDropped;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_resolved  <= '0;
            r_now       <= 32'd0;
            r_res_valid <= 1'b0;
        end else begin
            // in S_EXEC the beat is replaced, not cleared
            if (r_res_valid && i_res_take && r_state != S_EXEC) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_i     <= '0;
                        r_hit   <= 1'b0;
                        r_free  <= 1'b0;
                        r_rv    <= 1'b0;
                        r_pv    <= 1'b0;
                        r_state <= (i_cmd.op == OP_TICK || i_cmd.op == OP_DROP)
                                 ? S_EXEC : S_SCAN;
                    end
                end
                S_SCAN: begin
                    // one entry a cycle: match, first free, oldest resolved, oldest of any valid entry
                    if (r_valid[idx]) begin
                        if (!r_hit && r_addr_mem[idx] == r_cmd.addr) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= idx;
                        end
                        if (r_resolved[idx]) begin
                            if (!r_rv || age > r_rv_age) begin
                                r_rv     <= 1'b1;
                                r_rv_idx <= idx;
                                r_rv_age <= age;
                            end
                        end
                        if (!r_pv || age > r_pv_age) begin
                            r_pv     <= 1'b1;
                            r_pv_idx <= idx;
                            r_pv_age <= age;
                        end
                    end else if (!r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= idx;
                    end
                    if (r_i == LastIdx) r_state <= S_READ;
                    r_i <= r_i + 1'b1;
                end
                S_READ: begin
                    r_rd_hw   <= r_hw_mem[r_hit_idx];
                    r_rd_use  <= hit_age;
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    if (!r_res_valid || i_res_take) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        r_res       <= n_res;
                        case (r_cmd.op)
                            OP_TICK: r_now <= r_now + 32'd1;
                            OP_RESOLVE: begin
                                if (r_hit && r_resolved[r_hit_idx]) begin
                                    r_use_mem[r_hit_idx] <= r_now;
                                end else if (!r_hit) begin
                                    r_addr_mem[slot] <= r_cmd.addr;
                                    r_hw_mem[slot]   <= 48'd0;
                                    r_use_mem[slot]  <= r_now;
                                    r_valid[slot]    <= 1'b1;
                                    r_resolved[slot] <= 1'b0;
                                end
                            end
                            OP_LEARN_REQ: begin
                                r_addr_mem[slot] <= r_cmd.addr;
                                r_hw_mem[slot]   <= r_cmd.hw;
                                r_use_mem[slot]  <= r_now;
                                r_valid[slot]    <= 1'b1;
                                r_resolved[slot] <= 1'b1;
                            end
                            OP_LEARN_REP: begin
                                if (r_hit) begin
                                    r_hw_mem[r_hit_idx]   <= r_cmd.hw;
                                    r_use_mem[r_hit_idx]  <= r_now;
                                    r_resolved[r_hit_idx] <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
